// ===== design/bse_pkg.sv =====
`default_nettype none
package bse_pkg;
    localparam int MaxLength    = 65536;
    localparam int FractionBits = 16;
    localparam int NumBins      = 256;
    localparam int BinW         = $clog2(MaxLength + 1);
    localparam int BinAw        = 8;
    localparam int KW           = $clog2(BinW);
    localparam int LgW          = KW + 32;
    localparam int SumW         = BinW + LgW;
    localparam int DivW         = LgW + 1;
    localparam int OutW         = 20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic [OutW-1:0] entropy_bits;
        logic            length_overflow;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic count_byte;
        logic clr_start;
        logic clr_step;
        logic scan_start;
        logic scan_step;
        logic lg_start;
        logic lg_sel_n;
        logic acc_add;
        logic div_start;
        logic lgn_start;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic bin_zero;
        logic lg_done;
        logic div_done;
        logic total_zero;
    } t_sts;
endpackage
`default_nettype wire

// ===== design/bse_ram.sv =====
`default_nettype none
module bse_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/bse_log2.sv =====
`default_nettype none
// iterative log2 in Q.32: one squaring per cycle
module bse_log2 (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [bse_pkg::BinW-1:0]   i_x,
    output logic                      o_done,
    output logic [bse_pkg::LgW-1:0]   o_lg
);
    import bse_pkg::*;

    logic          r_busy;
    logic [5:0]    r_cnt;
    logic [32:0]   r_m;
    logic [31:0]   r_frac;
    logic [KW-1:0] r_k;
    logic [KW-1:0] n_k;
    logic [65:0]   w_sq;
    logic [34:0]   w_m2;

    always_comb begin
        n_k = '0;
        for (int i = 0; i < BinW; i++) begin
            if (i_x[i]) begin
                n_k = KW'(i);
            end
        end
    end

    assign w_sq = r_m * r_m;
    assign w_m2 = w_sq[65:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_k    <= n_k;
                r_frac <= '0;
                r_m    <= 33'({i_x, 31'b0} >> n_k);
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (w_m2[34:32] != 3'b0) begin
                    r_m    <= w_m2[33:1];
                    r_frac <= {r_frac[30:0], 1'b1};
                end else begin
                    r_m    <= w_m2[32:0];
                    r_frac <= {r_frac[30:0], 1'b0};
                end
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_lg = {r_k, r_frac};
endmodule
`default_nettype wire

// ===== design/bse_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module bse_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [bse_pkg::SumW-1:0]   i_num,
    input  wire [bse_pkg::BinW-1:0]   i_den,
    output logic                      o_done,
    output logic [bse_pkg::DivW-1:0]  o_quo
);
    import bse_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic            r_busy;
    logic [CntW-1:0] r_cnt;
    logic [SumW-1:0] r_num;
    logic [BinW-1:0] r_den;
    logic [BinW:0]   r_rem;
    logic [BinW:0]   w_sh;

    assign w_sh = {r_rem[BinW-1:0], r_num[SumW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_num <= {r_num[SumW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_num <= {r_num[SumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(SumW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_num[DivW-1:0];
endmodule
`default_nettype wire

// ===== design/bse_datapath.sv =====
`default_nettype none
module bse_datapath (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  bse_pkg::t_req  i_req,
    input  bse_pkg::t_cmd  i_cmd,
    output bse_pkg::t_sts  o_sts,
    output bse_pkg::t_res  o_res
);
    import bse_pkg::*;

    logic [BinW-1:0]  r_total;
    logic             r_ovf;
    logic [BinAw:0]   r_addr;
    logic [BinW-1:0]  r_bin;
    logic [SumW-1:0]  r_sum;
    logic [LgW-1:0]   r_lgn;
    logic [DivW-1:0]  r_q;
    logic             r_pend;
    logic [BinAw-1:0] r_paddr;
    logic             r_hit;
    logic [BinW-1:0]  r_fdata;
    logic [BinW-1:0]  w_rdata;
    logic [BinW-1:0]  w_rd;
    logic             w_we;
    logic [BinAw-1:0] w_waddr;
    logic [BinW-1:0]  w_wdata;
    logic [BinAw-1:0] w_raddr;
    logic             w_cnt;
    logic             w_lg_done;
    logic [LgW-1:0]   w_lg;
    logic             w_div_done;
    logic [DivW-1:0]  w_quo;
    logic [DivW:0]    w_h;
    logic [DivW:0]    w_hr;

    assign w_cnt = i_cmd.count_byte && i_req.byte_present
                   && (r_total != BinW'(MaxLength));
    // bypass a write that landed on the address read in the same cycle
    assign w_rd = r_hit ? r_fdata : w_rdata;

    always_comb begin
        w_raddr = i_req.data_byte;
        if (i_cmd.scan_start || i_cmd.scan_step) begin
            w_raddr = i_cmd.scan_start ? '0 : r_addr[BinAw-1:0];
        end
    end

    // a byte reads the ram in its accept cycle and writes the bin next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_pend <= w_cnt;
            r_hit  <= w_we && (w_waddr == w_raddr);
        end
        r_paddr <= i_req.data_byte;
        r_fdata <= w_wdata;
    end

    assign w_we    = i_cmd.clr_step || r_pend;
    assign w_waddr = i_cmd.clr_step ? r_addr[BinAw-1:0] : r_paddr;
    assign w_wdata = i_cmd.clr_step ? '0 : w_rd + BinW'(1);

    bse_ram #(.Width(BinW), .Depth(NumBins)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    bse_log2 u_log2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.lg_start),
        .i_x    (i_cmd.lg_sel_n ? r_total : w_rd),
        .o_done (w_lg_done),
        .o_lg   (w_lg)
    );

    bse_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_sum + SumW'(r_total >> 1)),
        .i_den  (r_total),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_addr  <= '0;
        end else begin
            if (w_cnt) begin
                r_total <= r_total + BinW'(1);
            end
            if (i_cmd.count_byte && i_req.byte_present && !w_cnt) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.clr_start || i_cmd.scan_start) begin
                r_addr <= i_cmd.scan_start ? (BinAw+1)'(1) : '0;
            end else if (i_cmd.clr_step || i_cmd.scan_step) begin
                r_addr <= r_addr + (BinAw+1)'(1);
            end
            if (i_cmd.emit) begin
                r_total <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lg_start && !i_cmd.lg_sel_n) begin
            r_bin <= w_rd;
        end
        if (i_cmd.scan_start) begin
            r_sum <= '0;
        end else if (i_cmd.acc_add) begin
            r_sum <= r_sum + SumW'(r_bin) * SumW'(w_lg);
        end
        if (i_cmd.lgn_start) begin
            r_lgn <= w_lg;
        end
        if (w_div_done) begin
            r_q <= w_quo;
        end
    end

    assign w_h  = ({2'b0, r_lgn} > {1'b0, r_q}) ? ({2'b0, r_lgn} - {1'b0, r_q}) : '0;
    assign w_hr = (w_h + (DivW+1)'(64'd1 << (31 - FractionBits))) >> (32 - FractionBits);

    always_comb begin
        o_res.length_overflow = r_ovf;
        if (r_total == '0) begin
            o_res.entropy_bits = '0;
        end else if (w_hr > (DivW+1)'((1 << OutW) - 1)) begin
            o_res.entropy_bits = '1;
        end else begin
            o_res.entropy_bits = w_hr[OutW-1:0];
        end
    end

    assign o_sts.clr_done   = (r_addr[BinAw-1:0] == '1);
    assign o_sts.scan_done  = r_addr[BinAw];
    assign o_sts.bin_zero   = (w_rd == '0);
    assign o_sts.lg_done    = w_lg_done;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.total_zero = (r_total == '0);
endmodule
`default_nettype wire

// ===== design/bse_ctrl.sv =====
`default_nettype none
module bse_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  bse_pkg::t_req  i_req,
    input  bse_pkg::t_sts  i_sts,
    output bse_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import bse_pkg::*;

    localparam logic [3:0] S_RUN   = 4'd0;
    localparam logic [3:0] S_FLUSH = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_BIN   = 4'd3;
    localparam logic [3:0] S_LGW   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_LGN   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_LGNW  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_acc;

    assign w_acc = i_start && (r_state == S_RUN);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            S_RUN: begin
                o_cmd.count_byte = i_start;
                if (w_acc && i_req.last_byte) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.total_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_BIN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_LGN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                if (i_sts.bin_zero) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.lg_start = 1'b1;
                    n_state = S_LGW;
                end
            end
            S_LGW: begin
                if (i_sts.lg_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_SCAN;
            end
            S_LGN: begin
                o_cmd.lg_start  = 1'b1;
                o_cmd.lg_sel_n  = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_LGNW;
            end
            S_LGNW: begin
                o_cmd.lg_sel_n = 1'b1;
                if (i_sts.lg_done) begin
                    o_cmd.lgn_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_done = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.clr_start = 1'b1;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_RUN);
endmodule
`default_nettype wire

// ===== design/byte_shannon_entropy.sv =====
`default_nettype none
// channel   | ports                      | timing
// request   | i_start, o_busy, i_req     | taken when i_start and not o_busy
// result    | o_valid, o_res             | one-cycle strobe, no back-pressure
//
// bytes are taken one per cycle while o_busy is low
// a request with last_byte set closes the buffer: each non-empty bin takes
// a run of the shared log2 unit (one squaring a cycle), empty bins are
// skipped; then log2 of the length and the divider run in parallel
// after the result a sweep clears every bin of the histogram ram
// the same sweep runs after reset, with o_busy high
module byte_shannon_entropy (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  bse_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_valid,
    output bse_pkg::t_res  o_res
);
    import bse_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_res w_res;
    logic w_done;

    // controller sequences the scan, log2, divide and clear phases
    bse_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (o_busy),
        .o_done (w_done)
    );

    // histogram ram, counters and arithmetic
    bse_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_res  (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_done;
        end
        if (w_done) begin
            o_res <= w_res;
        end
    end

`ifndef NO_ASSERTIONS
    // a result only follows a busy period
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result without busy");
    // strobe lasts one cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe held");
    // entropy never above eight bits per byte
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.entropy_bits <= 20'h80000) else $error("entropy range");
`endif
endmodule
`default_nettype wire

// ===== sim/byte_shannon_entropy_tb.sv =====
module byte_shannon_entropy_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    // the scoreboard keeps its own histogram and queues the entropy it expects
    class entropy_board;
        int unsigned     hist[NumBins];
        int unsigned     n_bytes;
        bit              ovf;
        t_res            pending[$];
        int unsigned     n_errors;
        int unsigned     n_checked;

        function new();
            clear();
            n_errors  = 0;
            n_checked = 0;
        endfunction

        function void clear();
            foreach (hist[i]) hist[i] = 0;
            n_bytes = 0;
            ovf     = 1'b0;
        endfunction

        // log2 of x in unsigned q.32, by repeated squaring of the mantissa
        function logic [63:0] log2_q32(int unsigned x);
            int unsigned k;
            logic [63:0] m;
            logic [63:0] fr;
            k  = 0;
            fr = '0;
            if (x == 0) return '0;
            while (k < 31 && (x >> (k + 1)) != 0) k++;
            m = 64'(x) << (31 - k);
            for (int i = 1; i <= 32; i++) begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000) begin
                    m = m >> 1;
                    fr[32 - i] = 1'b1;
                end
            end
            return (64'(k) << 32) | fr;
        endfunction

        function logic [OutW-1:0] entropy_of_hist();
            logic [63:0] s;
            logic [63:0] q;
            logic [63:0] lgn;
            logic [63:0] h;
            logic [63:0] n;
            n = 64'(n_bytes);
            s = '0;
            if (n == 0) return '0;
            foreach (hist[i])
                if (hist[i] != 0) s += 64'(hist[i]) * log2_q32(hist[i]);
            q   = (s + n / 2) / n;
            lgn = log2_q32(n_bytes);
            h   = (lgn > q) ? lgn - q : 64'd0;
            if (FractionBits < 32)
                h = (h + (64'd1 << (31 - FractionBits))) >> (32 - FractionBits);
            if (h > 64'hF_FFFF) h = 64'hF_FFFF;
            return h[OutW-1:0];
        endfunction

        function void note_request(t_req r);
            t_res e;
            if (r.byte_present) begin
                if (n_bytes >= MaxLength) ovf = 1'b1;
                else begin
                    hist[r.data_byte]++;
                    n_bytes++;
                end
            end
            if (r.last_byte) begin
                e.entropy_bits    = entropy_of_hist();
                e.length_overflow = ovf;
                pending.push_back(e);
                clear();
            end
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", got, got);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.entropy_bits !== e.entropy_bits ||
                got.length_overflow !== e.length_overflow)
                report_mismatch("result differs", got, e);
        endfunction

        function void report_mismatch(string what, t_res got, t_res exp_r);
            n_errors++;
            $display("ERROR %0t: %s: entropy %0d ovf %0d, want entropy %0d ovf %0d",
                     $realtime, what, got.entropy_bits, got.length_overflow,
                     exp_r.entropy_bits, exp_r.length_overflow);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_valid;
    t_res o_res;

    entropy_board sb;
    int unsigned  gap_pct;
    int unsigned  n_requests;
    int unsigned  n_buffers;

    byte_shannon_entropy DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // result strobes are taken at the edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_res);
    end

    // offer one request, hold it until it is taken; random idle cycles first
    task automatic send_request(input logic [7:0] b, input logic pres, input logic lst);
        t_req r;
        r.data_byte    = b;
        r.byte_present = pres;
        r.last_byte    = lst;
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        // accepted at this edge
        sb.note_request(r);
        n_requests++;
        if (lst) n_buffers++;
    endtask

    // a random buffer: mostly short, skewed alphabets so entropies spread out
    task automatic send_buffer(input int unsigned len, input int unsigned alpha);
        for (int unsigned i = 0; i < len; i++)
            send_request(8'($urandom_range(alpha)) ^ 8'($urandom_range(1) ? 8'hA5 : 8'h00),
                         1'b1, i == len - 1);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb         = new();
        n_requests = 0;
        n_buffers  = 0;
        gap_pct    = 0;
        i_start    = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single bytes at the extremes, give zero entropy
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hFF, 1'b1, 1'b1);
        // empty buffer and a request that does nothing
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1);
        // two distinct bytes: one bit; closed by a mark with no byte
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        // four equal bytes then four distinct
        for (int i = 0; i < 4; i++) send_request(8'h77, 1'b1, i == 3);
        for (int i = 0; i < 4; i++) send_request(8'(1 << i), 1'b1, i == 3);
        drain();

        // every byte value once: eight bits exactly
        for (int i = 0; i < 256; i++) send_request(8'(i), 1'b1, i == 255);
        drain();

        // random phases with different sender pacing
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 6 : (ph == 1) ? 49 : 0;
            for (int k = 0; k < 35; k++) begin
                case ($urandom_range(9))
                    0: send_request(8'($urandom), 1'b0, 1'($urandom_range(1)));
                    1: send_request(8'($urandom), 1'b1, 1'b1);
                    default: send_buffer($urandom_range(2, 12), $urandom_range(255));
                endcase
                // sender holds off until all results are in
                if (k == 20) begin
                    i_start <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
        end
        drain();

        $display("ran %0d requests in %0d buffers, %0d results checked",
                 n_requests, n_buffers, sb.n_checked);
        $display("covered empty, single byte, full alphabet and random short buffers");
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
